// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file of the allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, disabled while reset is high.
`define BFHA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also holds across reset.
`define BFHA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/bfha_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfha_pkg: shared types and constants of the best-fit heap allocator
// Request and result payloads, operation and status codes, default sizes.
// ----------------------------------------------------------------------------
package bfha_pkg;

   localparam int FIELD_W          = 20;
   localparam int MAX_SEGMENTS_DEF = 64;
   localparam int ADDR_BITS_DEF    = 20;
   localparam int ALIGN_BYTES_DEF  = 8;
   localparam int HEADER_BYTES     = 16;

   localparam logic [FIELD_W-1:0] HEAP_RESET = 20'd65536;

   localparam logic [1:0] REQ_ALLOC = 2'd0;
   localparam logic [1:0] REQ_FREE  = 2'd1;
   localparam logic [1:0] REQ_INIT  = 2'd2;
   localparam logic [1:0] REQ_NOP   = 2'd3;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_NOFIT   = 2'd1;
   localparam logic [1:0] STAT_BADFREE = 2'd2;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [FIELD_W-1:0] size_bytes;
      logic [FIELD_W-1:0] address;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [FIELD_W-1:0] data_address;
      logic [FIELD_W-1:0] granted_bytes;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ===== rtl/bfha_seg_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfha_seg_ram: segment table storage
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module bfha_seg_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 41
) (
   input  wire logic                     clock,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/bfha_rem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfha_rem: remainder by the alignment
// The alignment is a power of two, so the remainder is the low bits of the
// value; it is registered and flagged done in the cycle after start.
// ----------------------------------------------------------------------------
module bfha_rem
   import bfha_pkg::*;
#(
   parameter int ALIGN_BYTES = ALIGN_BYTES_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [FIELD_W-1:0]             value,
   output      logic                           done,
   output      logic [$clog2(ALIGN_BYTES)-1:0] remainder
);

   localparam int RW = $clog2(ALIGN_BYTES);

   logic [RW-1:0] r_ff, r_in;
   logic          done_ff, done_in;

   always_comb begin
      r_in    = r_ff;
      done_in = 1'b0;
      if (start) begin
         r_in    = value[RW-1:0];
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
      r_ff <= r_in;
   end

   assign done      = done_ff;
   assign remainder = r_ff;

endmodule

`default_nettype wire

// ===== rtl/best_fit_heap_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// best_fit_heap_allocator: best-fit segment allocator with coalescing
// Segment table in a RAM, walked one entry per cycle by a small sequencer.
// ----------------------------------------------------------------------------
//   channel   ports                              handshake
//   request   start, busy, req_data              taken when start & !busy
//   result    rsp_valid, rsp_data                one-cycle strobe
//   config    csr_valid, csr_ready, csr_data     taken when valid & ready
//
// Alloc: alignment rounding (S_BOOT, S_RDIV), the best-fit walk (S_ASCAN),
// the split decision (S_ADEC), a move of the entries above the split when a
// split opens a slot (S_ASHIFT, S_AWSPL), then the update (S_AWBEST).
// Free: a walk up to the hit (S_FSCAN), a check of the neighbors on each side
// (S_FDOWN, S_FUP), the merged write (S_FWR), a move down after a merge (S_FCOMP).
// Init: S_BOOT, S_RDIV, S_INIT. Rate is set by the single RAM read port.
// Reset rebuilds the pool (busy). Results cannot be stalled.
// ----------------------------------------------------------------------------
module best_fit_heap_allocator
   import bfha_pkg::*;
#(
   parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
   parameter int ADDR_BITS    = ADDR_BITS_DEF,
   parameter int ALIGN_BYTES  = ALIGN_BYTES_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output      logic               busy,
   input  wire req_payload_type    req_data,
   output      logic               rsp_valid,
   output      rsp_payload_type    rsp_data,
   input  wire logic               csr_valid,
   output      logic               csr_ready,
   input  wire logic [FIELD_W-1:0] csr_data
);

   localparam int AW     = ADDR_BITS;
   localparam int IW     = $clog2(MAX_SEGMENTS);
   localparam int CNW    = $clog2(MAX_SEGMENTS + 1);
   localparam int EW     = 2 * AW + 1;
   localparam int RW     = $clog2(ALIGN_BYTES);
   localparam int SW     = (AW > FIELD_W) ? AW : FIELD_W;
   localparam int CMPW   = SW + 1;
   localparam int WANT_W = FIELD_W + 1;

   typedef enum logic [13:0] {
      S_BOOT   = 14'b00000000000001,
      S_IDLE   = 14'b00000000000010,
      S_RDIV   = 14'b00000000000100,
      S_INIT   = 14'b00000000001000,
      S_ASCAN  = 14'b00000000010000,
      S_ADEC   = 14'b00000000100000,
      S_ASHIFT = 14'b00000001000000,
      S_AWSPL  = 14'b00000010000000,
      S_AWBEST = 14'b00000100000000,
      S_FSCAN  = 14'b00001000000000,
      S_FDOWN  = 14'b00010000000000,
      S_FUP    = 14'b00100000000000,
      S_FWR    = 14'b01000000000000,
      S_FCOMP  = 14'b10000000000000
   } state_type;

   state_type          state_ff, state_in;
   logic [FIELD_W-1:0] heap_ff, heap_in;
   logic               boot_ff, boot_in;
   logic               is_init_ff, is_init_in;
   logic [FIELD_W-1:0] size_ff, size_in;
   logic [FIELD_W-1:0] addr_ff, addr_in;
   logic [WANT_W-1:0]  want_ff, want_in;
   logic [CNW-1:0]     n_ff, n_in;
   logic [IW-1:0]      ptr_ff, ptr_in;
   logic               more_ff, more_in;
   logic               pend_ff, pend_in;
   logic [IW-1:0]      pidx_ff, pidx_in;
   logic               found_ff, found_in;
   logic               exact_ff, exact_in;
   logic               split_ff, split_in;
   logic [IW-1:0]      best_ff, best_in;
   logic [AW-1:0]      bstart_ff, bstart_in;
   logic [AW-1:0]      bsize_ff, bsize_in;
   logic [IW-1:0]      hit_ff, hit_in;
   logic [IW-1:0]      lo_ff, lo_in;
   logic [IW-1:0]      hi_ff, hi_in;
   logic [AW-1:0]      lostart_ff, lostart_in;
   logic [AW-1:0]      acc_ff, acc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_data_ff, rsp_data_in;

   logic               rd_en, wr_en;
   logic [IW-1:0]      rd_addr, wr_addr;
   logic [EW-1:0]      rd_data, wr_data;
   logic               rem_start, rem_done;
   logic [RW-1:0]      rem_value;
   logic [FIELD_W-1:0] rem_src;

   logic [AW-1:0]      rd_start, rd_size;
   logic               rd_used;
   logic [IW-1:0]      last_idx, gap;
   logic [CMPW-1:0]    hdr_c, want_c, rd_size_c, bsize_c;
   logic               fit, tighter, exact_hit, addr_hit, split_ok;
   logic [SW-1:0]      match_sum, data_sum;
   logic [AW-1:0]      merge_acc, new_start, new_rsize, grant_size, init_size;
   logic [FIELD_W-1:0] usable;

   bfha_seg_ram #(
      .DEPTH (MAX_SEGMENTS),
      .WIDTH (EW)
   ) u_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   bfha_rem #(
      .ALIGN_BYTES (ALIGN_BYTES)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .value     (rem_src),
      .done      (rem_done),
      .remainder (rem_value)
   );

   assign rem_src = is_init_ff ? heap_ff : size_ff;

   // Entry layout: {used, size, start}
   assign rd_start = rd_data[AW-1:0];
   assign rd_size  = rd_data[2*AW-1:AW];
   assign rd_used  = rd_data[2*AW];

   assign last_idx  = IW'(n_ff - CNW'(1));
   assign gap       = hi_ff - lo_ff;
   assign hdr_c     = CMPW'(HEADER_BYTES);
   assign want_c    = CMPW'(want_ff);
   assign rd_size_c = CMPW'(rd_size);
   assign bsize_c   = CMPW'(bsize_ff);
   assign fit       = !rd_used && (rd_size_c >= want_c);
   assign tighter   = !found_ff || (bsize_ff > rd_size);
   assign exact_hit = (rd_size_c == want_c);
   assign match_sum = SW'(rd_start) + SW'(HEADER_BYTES);
   assign addr_hit  = rd_used && (match_sum[FIELD_W-1:0] == addr_ff);
   assign merge_acc = acc_ff + rd_size + AW'(HEADER_BYTES);
   assign split_ok  = !exact_ff && ((bsize_c - want_c) > hdr_c) &&
                      (n_ff < CNW'(MAX_SEGMENTS));
   assign new_start  = AW'(CMPW'(bstart_ff) + hdr_c + want_c);
   assign new_rsize  = AW'(bsize_c - want_c - hdr_c);
   assign grant_size = split_ff ? AW'(want_ff) : bsize_ff;
   assign data_sum   = SW'(bstart_ff) + SW'(HEADER_BYTES);
   assign usable     = heap_ff - FIELD_W'(rem_value);
   assign init_size  = (usable > FIELD_W'(HEADER_BYTES)) ?
                       AW'(usable - FIELD_W'(HEADER_BYTES)) : '0;

   always_comb begin
      state_in     = state_ff;
      heap_in      = heap_ff;
      boot_in      = boot_ff;
      is_init_in   = is_init_ff;
      size_in      = size_ff;
      addr_in      = addr_ff;
      want_in      = want_ff;
      n_in         = n_ff;
      ptr_in       = ptr_ff;
      more_in      = more_ff;
      pend_in      = 1'b0;
      pidx_in      = pidx_ff;
      found_in     = found_ff;
      exact_in     = exact_ff;
      split_in     = split_ff;
      best_in      = best_ff;
      bstart_in    = bstart_ff;
      bsize_in     = bsize_ff;
      hit_in       = hit_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      lostart_in   = lostart_ff;
      acc_in       = acc_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;
      rd_addr      = ptr_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rem_start    = 1'b0;

      if (csr_valid && csr_ready) begin
         heap_in = csr_data;
      end

      case (state_ff)
         S_BOOT: begin
            rem_start = 1'b1;
            state_in  = S_RDIV;
         end

         S_IDLE: begin
            if (start) begin
               case (req_data.req_type)
                  REQ_ALLOC: begin
                     is_init_in = 1'b0;
                     size_in    = req_data.size_bytes;
                     state_in   = S_BOOT;
                  end
                  REQ_FREE: begin
                     addr_in  = req_data.address;
                     ptr_in   = '0;
                     more_in  = 1'b1;
                     state_in = S_FSCAN;
                  end
                  REQ_INIT: begin
                     is_init_in = 1'b1;
                     state_in   = S_BOOT;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '{status: STAT_OK, data_address: '0,
                                      granted_bytes: '0};
                  end
               endcase
            end
         end

         S_RDIV: begin
            if (rem_done) begin
               if (is_init_ff) begin
                  state_in = S_INIT;
               end else begin
                  want_in = WANT_W'(size_ff) + ((rem_value == '0) ? '0 :
                            (WANT_W'(ALIGN_BYTES) - WANT_W'(rem_value)));
                  ptr_in   = last_idx;
                  more_in  = 1'b1;
                  found_in = 1'b0;
                  exact_in = 1'b0;
                  state_in = S_ASCAN;
               end
            end
         end

         S_INIT: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = {1'b0, init_size, AW'(0)};
            n_in    = CNW'(1);
            boot_in = 1'b0;
            if (!boot_ff) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{status: STAT_OK, data_address: '0, granted_bytes: '0};
            end
            state_in = S_IDLE;
         end

         S_ASCAN: begin
            // walk from the highest entry down
            if (more_ff) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               pidx_in = ptr_ff;
               if (ptr_ff == '0) begin
                  more_in = 1'b0;
               end else begin
                  ptr_in = ptr_ff - IW'(1);
               end
            end
            if (pend_ff) begin
               if (fit && tighter) begin
                  best_in   = pidx_ff;
                  bstart_in = rd_start;
                  bsize_in  = rd_size;
                  found_in  = 1'b1;
                  if (exact_hit) begin
                     exact_in = 1'b1;
                     state_in = S_ADEC;
                  end
               end
               if (pidx_ff == '0) begin
                  state_in = S_ADEC;
               end
            end else if (!more_ff) begin
               state_in = S_ADEC;
            end
            if (state_in == S_ADEC) begin
               pend_in = 1'b0;
               more_in = 1'b0;
            end
         end

         S_ADEC: begin
            if (!found_ff) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{status: STAT_NOFIT, data_address: '0, granted_bytes: '0};
               state_in     = S_IDLE;
            end else if (split_ok) begin
               split_in = 1'b1;
               ptr_in   = last_idx;
               more_in  = (last_idx > best_ff);
               state_in = S_ASHIFT;
            end else begin
               split_in = 1'b0;
               state_in = S_AWBEST;
            end
         end

         S_ASHIFT: begin
            // move entries above the split up by one slot
            if (more_ff) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               pidx_in = ptr_ff;
               if (ptr_ff == IW'(best_ff + IW'(1))) begin
                  more_in = 1'b0;
               end else begin
                  ptr_in = ptr_ff - IW'(1);
               end
            end
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pidx_ff + IW'(1);
               wr_data = rd_data;
            end
            if (!more_ff) begin
               pend_in  = 1'b0;
               state_in = S_AWSPL;
            end
         end

         S_AWSPL: begin
            wr_en    = 1'b1;
            wr_addr  = best_ff + IW'(1);
            wr_data  = {1'b0, new_rsize, new_start};
            n_in     = n_ff + CNW'(1);
            state_in = S_AWBEST;
         end

         S_AWBEST: begin
            wr_en        = 1'b1;
            wr_addr      = best_ff;
            wr_data      = {1'b1, grant_size, bstart_ff};
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{status: STAT_OK, data_address: data_sum[FIELD_W-1:0],
                             granted_bytes: FIELD_W'(grant_size)};
            state_in     = S_IDLE;
         end

         S_FSCAN: begin
            if (more_ff) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               pidx_in = ptr_ff;
               if (ptr_ff == last_idx) begin
                  more_in = 1'b0;
               end else begin
                  ptr_in = ptr_ff + IW'(1);
               end
            end
            if (pend_ff) begin
               if (addr_hit) begin
                  hit_in     = pidx_ff;
                  lo_in      = pidx_ff;
                  hi_in      = pidx_ff;
                  lostart_in = rd_start;
                  acc_in     = rd_size;
                  ptr_in     = pidx_ff - IW'(1);
                  more_in    = (pidx_ff != '0);
                  pend_in    = 1'b0;
                  state_in   = S_FDOWN;
               end else if (pidx_ff == last_idx) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{status: STAT_BADFREE, data_address: '0,
                                   granted_bytes: '0};
                  pend_in      = 1'b0;
                  more_in      = 1'b0;
                  state_in     = S_IDLE;
               end
            end
         end

         S_FDOWN: begin
            // absorb free neighbors below the freed entry
            if (more_ff) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               pidx_in = ptr_ff;
               if (ptr_ff == '0) begin
                  more_in = 1'b0;
               end else begin
                  ptr_in = ptr_ff - IW'(1);
               end
            end
            if (pend_ff) begin
               if (!rd_used) begin
                  acc_in     = merge_acc;
                  lo_in      = pidx_ff;
                  lostart_in = rd_start;
                  if (pidx_ff == '0) begin
                     state_in = S_FUP;
                  end
               end else begin
                  state_in = S_FUP;
               end
            end else if (!more_ff) begin
               state_in = S_FUP;
            end
            if (state_in == S_FUP) begin
               pend_in = 1'b0;
               ptr_in  = hit_ff + IW'(1);
               more_in = (hit_ff < last_idx);
            end
         end

         S_FUP: begin
            // absorb free neighbors above the freed entry
            if (more_ff) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               pidx_in = ptr_ff;
               if (ptr_ff == last_idx) begin
                  more_in = 1'b0;
               end else begin
                  ptr_in = ptr_ff + IW'(1);
               end
            end
            if (pend_ff) begin
               if (!rd_used) begin
                  acc_in = merge_acc;
                  hi_in  = pidx_ff;
                  if (pidx_ff == last_idx) begin
                     state_in = S_FWR;
                  end
               end else begin
                  state_in = S_FWR;
               end
            end else if (!more_ff) begin
               state_in = S_FWR;
            end
            if (state_in == S_FWR) begin
               pend_in = 1'b0;
               more_in = 1'b0;
            end
         end

         S_FWR: begin
            wr_en    = 1'b1;
            wr_addr  = lo_ff;
            wr_data  = {1'b0, acc_ff, lostart_ff};
            ptr_in   = hi_ff + IW'(1);
            more_in  = (hi_ff != lo_ff) && (hi_ff < last_idx);
            state_in = S_FCOMP;
         end

         S_FCOMP: begin
            // close the hole left by the merged entries
            if (more_ff) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               pidx_in = ptr_ff;
               if (ptr_ff == last_idx) begin
                  more_in = 1'b0;
               end else begin
                  ptr_in = ptr_ff + IW'(1);
               end
            end
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pidx_ff - gap;
               wr_data = rd_data;
            end
            if (!more_ff) begin
               pend_in      = 1'b0;
               n_in         = n_ff - CNW'(gap);
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{status: STAT_OK, data_address: '0, granted_bytes: '0};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_BOOT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_BOOT;
         heap_ff      <= HEAP_RESET;
         boot_ff      <= 1'b1;
         is_init_ff   <= 1'b1;
         n_ff         <= CNW'(1);
         more_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         heap_ff      <= heap_in;
         boot_ff      <= boot_in;
         is_init_ff   <= is_init_in;
         n_ff         <= n_in;
         more_ff      <= more_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      size_ff    <= size_in;
      addr_ff    <= addr_in;
      want_ff    <= want_in;
      ptr_ff     <= ptr_in;
      pidx_ff    <= pidx_in;
      found_ff   <= found_in;
      exact_ff   <= exact_in;
      split_ff   <= split_in;
      best_ff    <= best_in;
      bstart_ff  <= bstart_in;
      bsize_ff   <= bsize_in;
      hit_ff     <= hit_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      lostart_ff <= lostart_in;
      acc_ff     <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/bfha_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// bfha_checker: port-level checks of the allocator
// Watches request, result and busy behavior over time.
// ----------------------------------------------------------------------------
module bfha_checker
   import bfha_pkg::*;
(
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            start,
   input wire logic            busy,
   input wire req_payload_type req_data,
   input wire logic            rsp_valid,
   input wire rsp_payload_type rsp_data
);

   logic take_req;
   logic fail_rsp;
   logic fields_zero;

   assign take_req    = start && !busy && (req_data.req_type != REQ_NOP);
   assign fail_rsp    = rsp_valid && (rsp_data.status != STAT_OK);
   assign fields_zero = (rsp_data.data_address == '0) && (rsp_data.granted_bytes == '0);

   // the pool rebuild after reset keeps the block busy
   `BFHA_ASSERT_ALWAYS(a_boot_busy, clock, reset |=> busy, "not busy after reset")

   `BFHA_ASSERT(a_accept_busy, clock, reset, take_req |=> busy, "request taken, not busy")

   `BFHA_ASSERT(a_fail_zero, clock, reset, fail_rsp |-> fields_zero, "failed result not zero")

   `BFHA_ASSERT(a_rsp_cause, clock, reset, rsp_valid |-> ($past(busy) || $past(start)), "stray result")

endmodule

bind best_fit_heap_allocator bfha_checker u_bfha_checker (.*);

`default_nettype wire

// ===== test/best_fit_heap_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_heap_allocator_tb: self-checking bench for the heap allocator
// Drives alloc, free, init and no-op requests in several idle phases and pool sizes,
// predicts every result from a shadow segment table and compares field by field.
// ----------------------------------------------------------------------------
module best_fit_heap_allocator_tb;
   import bfha_pkg::*;

   localparam int          SEGS       = 64;
   localparam int          ALIGN      = 8;
   localparam int          STALL_MAX  = 20000;
   localparam int          SETTLE     = 300;

   typedef struct {
      req_payload_type req;
      bit              pick_live;
   } pending_req_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            start = 1'b0;
   logic            busy;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   rsp_payload_type rsp_data;
   logic            csr_valid = 1'b0;
   logic            csr_ready;
   logic [FIELD_W-1:0] csr_data = '0;

   pending_req_type    req_pending[$];
   rsp_payload_type    rsp_expected[$];
   logic [FIELD_W-1:0] heap_writes[$];
   int                 idle_pct = 0;
   int                 fail_count = 0;
   int                 stall_cycles = 0;

   // shadow segment table
   logic [FIELD_W-1:0] seg_base[SEGS];
   logic [FIELD_W-1:0] seg_len[SEGS];
   bit                 seg_taken[SEGS];
   bit                 seg_live[SEGS];
   logic [FIELD_W-1:0] pool_cfg;

   best_fit_heap_allocator u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic void pool_rebuild();
      logic [FIELD_W-1:0] usable;
      usable = FIELD_W'((pool_cfg / ALIGN) * ALIGN);
      for (int k = 0; k < SEGS; k++) begin
         seg_base[k] = '0;
         seg_len[k] = '0;
         seg_taken[k] = 1'b0;
         seg_live[k] = 1'b0;
      end
      seg_live[0] = 1'b1;
      seg_len[0] = (usable > HEADER_BYTES) ? FIELD_W'(usable - HEADER_BYTES) : '0;
   endfunction

   function automatic int live_segments();
      int n;
      n = 0;
      while (n < SEGS && seg_live[n]) n++;
      return n;
   endfunction

   function automatic rsp_payload_type grant_segment(logic [FIELD_W-1:0] req_size);
      rsp_payload_type r;
      int      n, best, i;
      bit      found, exact;
      longint  want;
      r = '0;
      r.status = STAT_NOFIT;
      n = live_segments();
      want = ((longint'(req_size) + ALIGN - 1) / ALIGN) * ALIGN;
      best = 0;
      found = 0;
      exact = 0;
      i = n;
      while (i > 0) begin
         i--;
         if (!seg_taken[i] && longint'(seg_len[i]) >= want &&
             (!found || seg_len[best] > seg_len[i])) begin
            best = i;
            found = 1;
            if (longint'(seg_len[i]) == want) begin
               exact = 1;
               break;
            end
         end
      end
      if (!found) return r;
      if (!exact && (longint'(seg_len[best]) - want) > HEADER_BYTES && n < SEGS) begin
         for (int j = n; j > best + 1; j--) begin
            seg_base[j] = seg_base[j-1];
            seg_len[j] = seg_len[j-1];
            seg_taken[j] = seg_taken[j-1];
            seg_live[j] = seg_live[j-1];
         end
         seg_base[best+1] = FIELD_W'(longint'(seg_base[best]) + HEADER_BYTES + want);
         seg_len[best+1] = FIELD_W'(longint'(seg_len[best]) - want - HEADER_BYTES);
         seg_taken[best+1] = 1'b0;
         seg_live[best+1] = 1'b1;
         seg_len[best] = FIELD_W'(want);
      end
      seg_taken[best] = 1'b1;
      r.status = STAT_OK;
      r.data_address = FIELD_W'(seg_base[best] + HEADER_BYTES);
      r.granted_bytes = seg_len[best];
      return r;
   endfunction

   function automatic rsp_payload_type release_segment(logic [FIELD_W-1:0] addr);
      rsp_payload_type r;
      int     n, i, lo, hi, gap;
      bit     hit;
      longint total;
      r = '0;
      n = live_segments();
      hit = 0;
      for (i = 0; i < n; i++) begin
         if (seg_taken[i] && FIELD_W'(seg_base[i] + HEADER_BYTES) == addr) begin
            hit = 1;
            break;
         end
      end
      if (!hit) begin
         r.status = STAT_BADFREE;
         return r;
      end
      seg_taken[i] = 1'b0;
      lo = i;
      while (lo > 0 && !seg_taken[lo-1]) lo--;
      hi = i;
      while (hi + 1 < n && !seg_taken[hi+1]) hi++;
      total = seg_len[lo];
      for (int k = lo + 1; k <= hi; k++) total += HEADER_BYTES + longint'(seg_len[k]);
      seg_len[lo] = FIELD_W'(total);
      gap = hi - lo;
      if (gap > 0) begin
         for (int k = lo + 1; k + gap < n; k++) begin
            seg_base[k] = seg_base[k+gap];
            seg_len[k] = seg_len[k+gap];
            seg_taken[k] = seg_taken[k+gap];
            seg_live[k] = seg_live[k+gap];
         end
         for (int k = n - gap; k < n; k++) begin
            seg_base[k] = '0;
            seg_len[k] = '0;
            seg_taken[k] = 1'b0;
            seg_live[k] = 1'b0;
         end
      end
      r.status = STAT_OK;
      return r;
   endfunction

   function automatic rsp_payload_type apply_request(req_payload_type q);
      rsp_payload_type r;
      r = '0;
      case (q.req_type)
         REQ_ALLOC: r = grant_segment(q.size_bytes);
         REQ_FREE:  r = release_segment(q.address);
         REQ_INIT:  pool_rebuild();
         default:   r = '0;
      endcase
      return r;
   endfunction

   // data address of a random used segment, or a random offset if none
   function automatic logic [FIELD_W-1:0] pick_used_address();
      int picks[$];
      for (int k = 0; k < live_segments(); k++)
         if (seg_taken[k]) picks.push_back(k);
      if (picks.size() == 0) return FIELD_W'($urandom);
      return FIELD_W'(seg_base[picks[$urandom_range(picks.size() - 1)]] + HEADER_BYTES);
   endfunction

   initial begin
      pool_cfg = HEAP_RESET;
      pool_rebuild();
   end

   // request driver
   always @(posedge clock) begin
      pending_req_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) rsp_expected.push_back(apply_request(req_data));
         if (!(start && busy)) begin
            if (req_pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
               nxt = req_pending.pop_front();
               if (nxt.pick_live) nxt.req.address = pick_used_address();
               req_data <= nxt.req;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // pool size register writes
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            pool_cfg = csr_data;
            csr_valid <= 1'b0;
         end else if (!csr_valid && heap_writes.size() > 0) begin
            csr_data <= heap_writes.pop_front();
            csr_valid <= 1'b1;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid) begin
         if (rsp_expected.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $realtime, rsp_data);
            fail_count++;
         end else begin
            want = rsp_expected.pop_front();
            if (rsp_data.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $realtime, want.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.data_address !== want.data_address) begin
               $display("%0t: data_address expected %0h actual %0h",
                        $realtime, want.data_address, rsp_data.data_address);
               fail_count++;
            end
            if (rsp_data.granted_bytes !== want.granted_bytes) begin
               $display("%0t: granted_bytes expected %0h actual %0h",
                        $realtime, want.granted_bytes, rsp_data.granted_bytes);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic queue_req(logic [1:0] kind, logic [FIELD_W-1:0] sz,
                            logic [FIELD_W-1:0] addr, bit live);
      pending_req_type p;
      p.req.req_type = kind;
      p.req.size_bytes = sz;
      p.req.address = addr;
      p.pick_live = live;
      req_pending.push_back(p);
   endtask

   // hold until every request is answered and the block is quiet
   task automatic wait_quiet();
      while (req_pending.size() > 0 || rsp_expected.size() > 0 || start)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic logic [FIELD_W-1:0] random_size();
      int r;
      r = $urandom_range(99);
      if (r < 70) return FIELD_W'($urandom_range(64));
      if (r < 90) return FIELD_W'($urandom_range(4096));
      if (r < 98) return FIELD_W'($urandom_range(65536));
      return FIELD_W'($urandom);
   endfunction

   initial begin
      int phase_idle[6] = '{0, 83, 0, 11, 83, 0};
      logic [FIELD_W-1:0] phase_heap[6] = '{20'd65536, 20'd64, 20'd1048575,
                                            20'd4100, 20'd200, 20'd65536};
      int roll;
      @(negedge reset);
      while (busy !== 1'b0) @(posedge clock);

      // directed: out of reset, before and after an init
      queue_req(REQ_ALLOC, 20'd0, '0, 0);
      queue_req(REQ_ALLOC, 20'd1, '0, 0);
      queue_req(REQ_ALLOC, 20'd8, '0, 0);
      queue_req(REQ_ALLOC, 20'hFFFFF, '0, 0);
      queue_req(REQ_FREE, '0, 20'd0, 0);
      queue_req(REQ_FREE, '0, 20'hFFFFF, 0);
      queue_req(REQ_FREE, '0, '0, 1);
      queue_req(REQ_FREE, '0, 20'd16, 0);
      queue_req(REQ_ALLOC, 20'd8, '0, 0);
      queue_req(REQ_NOP, 20'hFFFFF, 20'hFFFFF, 0);
      queue_req(REQ_ALLOC, 20'd100, '0, 0);
      queue_req(REQ_ALLOC, 20'd200, '0, 0);
      queue_req(REQ_ALLOC, 20'd300, '0, 0);
      queue_req(REQ_FREE, '0, 20'd16, 0);
      queue_req(REQ_FREE, '0, 20'd56, 0);
      queue_req(REQ_ALLOC, 20'd200, '0, 0);
      queue_req(REQ_ALLOC, 20'd65500, '0, 0);
      queue_req(REQ_INIT, '0, '0, 0);
      queue_req(REQ_ALLOC, 20'd65512, '0, 0);
      queue_req(REQ_FREE, '0, '0, 1);
      wait_quiet();

      for (int ph = 0; ph < 6; ph++) begin
         idle_pct = phase_idle[ph];
         heap_writes.push_back(phase_heap[ph]);
         while (heap_writes.size() > 0 || csr_valid) @(posedge clock);
         queue_req(REQ_INIT, FIELD_W'($urandom), FIELD_W'($urandom), 0);
         // fill the table on the large pool with small grants
         if (ph == 2)
            for (int k = 0; k < 70; k++) queue_req(REQ_ALLOC, FIELD_W'($urandom_range(40)), '0, 0);
         for (int k = 0; k < 310; k++) begin
            roll = $urandom_range(99);
            if (roll < 55)
               queue_req(REQ_ALLOC, random_size(), FIELD_W'($urandom), 0);
            else if (roll < 92)
               queue_req(REQ_FREE, FIELD_W'($urandom), '0, 1);
            else if (roll < 96)
               queue_req(REQ_FREE, FIELD_W'($urandom), FIELD_W'($urandom), 0);
            else if (roll < 98)
               queue_req(REQ_INIT, FIELD_W'($urandom), FIELD_W'($urandom), 0);
            else
               queue_req(REQ_NOP, FIELD_W'($urandom), FIELD_W'($urandom), 0);
         end
         wait_quiet();
      end

      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== best_fit_heap_allocator.f =====
+incdir+rtl
rtl/bfha_pkg.sv
rtl/bfha_seg_ram.sv
rtl/bfha_rem.sv
rtl/best_fit_heap_allocator.sv
rtl/bfha_checker.sv
test/best_fit_heap_allocator_tb.sv
